/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks at the end of the RTL modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* rtl/clist_pkg.sv */
// ---------------------------------------------------------------------------
// Cursor list package
// Sizes, operation codes and status codes of the cursor list engine.
// ---------------------------------------------------------------------------
package clist_pkg;

  localparam int DEPTH   = 64;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 2;

  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PREV   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEXT   = 3'd4;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

endpackage

/* rtl/cursor_list_engine_unit.sv */
// ---------------------------------------------------------------------------
// Cursor list engine
// Bounded ordered list of signed words with a cursor, held in one RAM.
// ---------------------------------------------------------------------------
// Each input word is one operation; each produces exactly one result word
// with a status, the removed item, the new length and the new cursor.
// Cursor moves and refused operations go from the idle state straight to the
// done state. Insert and remove move every item behind the cursor one place
// through the item RAM, which has one read port and one write port, one item
// per cycle with the read of the next item overlapping the write of the
// previous one. The done state loads the result word into the output register
// once that register is free. The block accepts no new word while an operation
// is in progress or while its result word still waits in the done state.
`include "assert_macros.svh"

module cursor_list_engine_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic        [clist_pkg::MODE_W-1:0] mode_i,
  input  logic signed [clist_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic        [clist_pkg::STAT_W-1:0] status_o,
  output logic signed [clist_pkg::DATA_W-1:0] removed_item_o,
  output logic        [clist_pkg::CNT_W-1:0]  length_o,
  output logic        [clist_pkg::CNT_W-1:0]  position_o
);
  import clist_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  cursor_q, cursor_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [ADDR_W-1:0] rp_q, rp_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic              rvalid_q, rvalid_d;
  logic              first_q, first_d;
  logic              ins_q, ins_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic [STAT_W-1:0] res_status_q, res_status_d;
  logic [DATA_W-1:0] res_item_q, res_item_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [DATA_W-1:0] out_item_q, out_item_d;
  logic [CNT_W-1:0]  out_len_q, out_len_d;
  logic [CNT_W-1:0]  out_pos_q, out_pos_d;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [DATA_W-1:0] mem_wd;

  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  count_less;
  logic [CNT_W-1:0]  span;

  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign count_less = count_q - CNT_W'(1);
  assign span       = count_q - cursor_q;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign removed_item_o = out_item_q;
  assign length_o       = out_len_q;
  assign position_o     = out_pos_q;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cursor_d     = cursor_q;
    left_d       = left_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    rvalid_d     = 1'b0;
    first_d      = first_q;
    ins_d        = ins_q;
    value_d      = value_q;
    res_status_d = res_status_q;
    res_item_d   = res_item_q;
    mem_we       = 1'b0;
    mem_wa       = wp_q;
    mem_wd       = rdata_q;

    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_item_d   = out_item_q;
    out_len_d    = out_len_q;
    out_pos_d    = out_pos_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_status_d = STATUS_OK;
          res_item_d   = '0;
          state_d      = ST_DONE;
          case (mode_i)
            MODE_INSERT: begin
              if (count_q == CNT_W'(DEPTH)) begin
                res_status_d = STATUS_FULL;
              end else begin
                left_d  = span;
                rp_d    = count_less[ADDR_W-1:0];
                wp_d    = count_q[ADDR_W-1:0];
                first_d = 1'b0;
                ins_d   = 1'b1;
                value_d = value_i;
                state_d = ST_SHIFT;
              end
            end
            MODE_REMOVE: begin
              if (cursor_q >= count_q) begin
                res_status_d = STATUS_EMPTY;
              end else begin
                left_d  = span;
                rp_d    = cursor_q[ADDR_W-1:0];
                wp_d    = cursor_q[ADDR_W-1:0];
                first_d = 1'b1;
                ins_d   = 1'b0;
                state_d = ST_SHIFT;
              end
            end
            MODE_START: begin
              cursor_d = '0;
            end
            MODE_PREV: begin
              if (cursor_q != '0) begin
                cursor_d = cursor_q - CNT_W'(1);
              end
            end
            MODE_NEXT: begin
              if (cursor_q < count_q) begin
                cursor_d = cursor_q + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SHIFT: begin
        // Each write uses the word read in the cycle before.
        if (left_q != '0) begin
          rvalid_d = 1'b1;
          left_d   = left_q - CNT_W'(1);
          rp_d     = ins_q ? rp_q - ADDR_W'(1) : rp_q + ADDR_W'(1);
        end
        if (rvalid_q) begin
          if (first_q) begin
            // The word at the cursor is the one being removed.
            res_item_d = rdata_q;
            first_d    = 1'b0;
          end else begin
            mem_we = 1'b1;
            wp_d   = ins_q ? wp_q - ADDR_W'(1) : wp_q + ADDR_W'(1);
          end
        end
        if (left_q == '0 && !rvalid_q) begin
          if (ins_q) begin
            mem_we  = 1'b1;
            mem_wa  = cursor_q[ADDR_W-1:0];
            mem_wd  = value_q;
            count_d = count_q + CNT_W'(1);
          end else begin
            count_d = count_less;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_item_d   = res_item_q;
          out_len_d    = count_q;
          out_pos_d    = cursor_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      left_q      <= '0;
      rvalid_q    <= 1'b0;
      first_q     <= 1'b0;
      ins_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cursor_q    <= cursor_d;
      left_q      <= left_d;
      rvalid_q    <= rvalid_d;
      first_q     <= first_d;
      ins_q       <= ins_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q         <= rp_d;
    wp_q         <= wp_d;
    value_q      <= value_d;
    res_status_q <= res_status_d;
    res_item_q   <= res_item_d;
    out_status_q <= out_status_d;
    out_item_q   <= out_item_d;
    out_len_q    <= out_len_d;
    out_pos_q    <= out_pos_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rp_q];
  end

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "length beyond depth")
  `ASSERT_ALWAYS(a_cursor_bound, clk_i, rst_ni, cursor_q <= count_q, "cursor beyond length")
  `ASSERT_IMPLIES(a_first_is_remove, clk_i, rst_ni, state_q == ST_SHIFT && first_q, !ins_q, "removed word captured during insert")
  `ASSERT_IMPLIES(a_done_loads, clk_i, rst_ni, state_q == ST_DONE && out_free, ##1 out_valid_q, "result not loaded")

endmodule
